// ===== rtl/gsfp_pkg.sv =====
// shared types and constants of the gnss sentence field parser
package gsfp_pkg;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_T      = 8'h54;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_POINT  = 8'h2E;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_VTAB   = 8'h0B;
   localparam logic [7:0] CHAR_FF     = 8'h0C;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;

   localparam int TIME_LEN = 17;
   localparam logic [4:0] FIELD_TIME  = 5'd1;
   localparam logic [4:0] FIELD_CHAR0 = 5'd10;
   localparam logic [4:0] FIELD_CHAR1 = 5'd11;
   localparam logic [4:0] FIELD_INT0  = 5'd12;
   localparam logic [4:0] FIELD_INT1  = 5'd13;

   localparam logic [63:0] MAG_CAP = 64'h8000_0000_0000_0000;
   localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

   localparam logic [0:0] CSR_ZONE = 1'b0;

   // one finished field handed from the front to the back
   typedef struct packed {
      logic [4:0]  field_number;
      logic        last;
      logic [63:0] mag;
      logic        neg;
      logic [4:0]  frac;
      logic [7:0]  first_char;
      logic        len_nonzero;
      logic        time_ok;
      logic [TIME_LEN-1:0][3:0] td;
   } field_type;

   // one result beat
   typedef struct packed {
      logic [4:0]  field_number;
      logic [63:0] number_value;
      logic [7:0]  char_value;
      logic        time_valid;
      logic [13:0] year_out;
      logic [3:0]  month_out;
      logic [4:0]  day_out;
      logic [4:0]  hour_out;
      logic [5:0]  minute_out;
      logic [5:0]  second_out;
      logic [9:0]  millisecond_out;
      logic        line_end;
   } result_type;

   // saturating m*10+d on a 64 bit magnitude
   function automatic logic [63:0] mul10_add(input logic [63:0] m, input logic [3:0] d);
      logic [67:0] p;
      begin
         p = {4'd0, m} * 68'd10 + {64'd0, d};
         mul10_add = (p > {4'd0, MAG_CAP}) ? MAG_CAP : p[63:0];
      end
   endfunction

   function automatic logic [6:0] two_dig(input logic [3:0] a, input logic [3:0] b);
      two_dig = 7'(a) * 7'd10 + 7'(b);
   endfunction

endpackage

// ===== rtl/gsfp_front.sv =====
// front end: line framing, field splitting and per character number accumulation
module gsfp_front #(
   parameter int SCALE_DIGITS = 7,
   parameter int FIELD_COUNT  = 19
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [7:0]           in_byte,
   output logic                 out_valid,
   output gsfp_pkg::field_type  out_field
);
   import gsfp_pkg::*;

   logic [2:0]  line_pos_ff;
   logic        header_ok_ff, in_line_ff, over_ff, done_ff, started_ff;
   logic [4:0]  fcnt_ff;
   logic [5:0]  flen_ff;
   logic [63:0] acc_ff;
   logic        neg_ff, point_ff;
   logic [4:0]  frac_ff;
   logic [7:0]  first_ff;
   logic [3:0]  td_ff [TIME_LEN];

   logic is_digit, is_end, is_comma, is_dollar, reportable, int_field;
   logic [2:0] pos_next;
   logic hdr_next;
   logic [3:0] dig;

   assign is_digit  = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
   assign dig       = is_digit ? 4'(in_byte - CHAR_ZERO) : 4'd0;
   assign is_end    = (in_byte == CHAR_CR) || (in_byte == CHAR_LF);
   assign is_comma  = (in_byte == CHAR_COMMA);
   assign is_dollar = (in_byte == CHAR_DOLLAR);
   assign pos_next  = (line_pos_ff < 3'd7) ? line_pos_ff + 3'd1 : line_pos_ff;
   assign hdr_next  = header_ok_ff || (pos_next == 3'd4 && in_byte == CHAR_T);
   assign int_field = (fcnt_ff == FIELD_INT0) || (fcnt_ff == FIELD_INT1);
   assign reportable = in_line_ff && !over_ff && fcnt_ff >= 5'd1 &&
                       fcnt_ff <= 5'(FIELD_COUNT);

   // field snapshot handed to the queue
   always_comb begin
      out_field.field_number = fcnt_ff;
      out_field.last         = is_end;
      out_field.mag          = acc_ff;
      out_field.neg          = neg_ff;
      out_field.frac         = frac_ff;
      out_field.first_char   = first_ff;
      out_field.len_nonzero  = (flen_ff != 6'd0);
      out_field.time_ok      = (flen_ff == 6'(TIME_LEN));
      for (int i = 0; i < TIME_LEN; i++) out_field.td[i] = td_ff[i];
   end

   always_comb begin
      out_valid = 1'b0;
      if (in_valid && !is_dollar && in_line_ff) begin
         if (is_end) out_valid = reportable && header_ok_ff;
         else if (is_comma) out_valid = reportable && hdr_next;
      end
   end

   // time digit store, written only while in field 1
   always_ff @(posedge clock) begin
      if (in_valid && in_line_ff && !is_dollar && !is_end && !is_comma &&
          fcnt_ff == FIELD_TIME && flen_ff < 6'(TIME_LEN)) begin
         td_ff[flen_ff[4:0]] <= dig;
      end
   end

   // line and field state
   always_ff @(posedge clock) begin
      if (reset) begin
         line_pos_ff <= '0; header_ok_ff <= 1'b0; in_line_ff <= 1'b0;
         fcnt_ff <= '0; over_ff <= 1'b0; flen_ff <= '0; acc_ff <= '0;
         neg_ff <= 1'b0; point_ff <= 1'b0; frac_ff <= '0; first_ff <= '0;
         done_ff <= 1'b0; started_ff <= 1'b0;
      end else if (in_valid) begin
         if (is_dollar || (in_line_ff && (is_end || is_comma))) begin
            flen_ff <= '0; acc_ff <= '0; neg_ff <= 1'b0; point_ff <= 1'b0;
            frac_ff <= '0; first_ff <= '0; done_ff <= 1'b0; started_ff <= 1'b0;
            if (is_dollar) begin
               in_line_ff <= 1'b1; line_pos_ff <= '0; header_ok_ff <= 1'b0;
               fcnt_ff <= '0; over_ff <= 1'b0;
            end else if (is_end) begin
               in_line_ff <= 1'b0;
            end else begin
               line_pos_ff <= pos_next; header_ok_ff <= hdr_next;
               if (fcnt_ff >= 5'(FIELD_COUNT)) over_ff <= 1'b1;
               else fcnt_ff <= fcnt_ff + 5'd1;
            end
         end else if (in_line_ff) begin
            line_pos_ff <= pos_next; header_ok_ff <= hdr_next;
            if (flen_ff == 6'd0) first_ff <= in_byte;
            if (flen_ff < 6'd63) flen_ff <= flen_ff + 6'd1;
            if (!done_ff) begin
               if (is_digit) begin
                  started_ff <= 1'b1;
                  if (!point_ff) acc_ff <= mul10_add(acc_ff, dig);
                  else if (frac_ff < 5'(SCALE_DIGITS)) begin
                     acc_ff <= mul10_add(acc_ff, dig);
                     frac_ff <= frac_ff + 5'd1;
                  end
               end else if (!started_ff && (in_byte == CHAR_SPACE ||
                            in_byte == CHAR_TAB || in_byte == CHAR_VTAB ||
                            in_byte == CHAR_FF)) begin
                  started_ff <= 1'b0;
               end else if (!started_ff && (in_byte == CHAR_PLUS ||
                            in_byte == CHAR_MINUS)) begin
                  started_ff <= 1'b1;
                  neg_ff <= (in_byte == CHAR_MINUS);
               end else if (in_byte == CHAR_POINT && !point_ff && !int_field) begin
                  started_ff <= 1'b1;
                  point_ff <= 1'b1;
               end else begin
                  done_ff <= 1'b1;
               end
            end
         end
      end
   end

`ifndef SYNTH
   a_frac_bound: assert property (@(posedge clock) disable iff (reset)
      frac_ff <= 5'(SCALE_DIGITS)) else $error("fraction count overrun");
   a_out_in_line: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> in_line_ff) else $error("field emitted outside a line");
   a_fcnt_bound: assert property (@(posedge clock) disable iff (reset)
      fcnt_ff <= 5'(FIELD_COUNT)) else $error("field counter overrun");
`endif
endmodule

// ===== rtl/gsfp_queue.sv =====
// short queue between front and back
module gsfp_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  gsfp_pkg::field_type wr_data,
   output logic                full,
   input  logic                rd_en,
   output logic                rd_valid,
   output gsfp_pkg::field_type rd_data
);
   import gsfp_pkg::*;
   localparam int AW = $clog2(DEPTH);

   field_type       mem_ff [DEPTH];
   logic [AW-1:0]   wp_ff, rp_ff;
   logic [AW:0]     cnt_ff;

   assign full     = (cnt_ff == (AW+1)'(DEPTH));
   assign rd_valid = (cnt_ff != '0);
   assign rd_data  = mem_ff[rp_ff];

   // storage
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wp_ff] <= wr_data;
   end

   // pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (wr_en) wp_ff <= (wp_ff == AW'(DEPTH-1)) ? '0 : wp_ff + AW'(1);
         if (rd_en) rp_ff <= (rp_ff == AW'(DEPTH-1)) ? '0 : rp_ff + AW'(1);
         cnt_ff <= cnt_ff + (AW+1)'(wr_en) - (AW+1)'(rd_en);
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (!full || rd_en)) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> rd_valid) else $error("queue underflow");
   a_count: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (AW+1)'(DEPTH)) else $error("queue count overrun");
`endif
endmodule

// ===== rtl/gsfp_back.sv =====
// back end: scaling, saturation and time conversion over a short pipeline
module gsfp_back #(
   parameter int SCALE_DIGITS = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [4:0]           zone_offset_hours,
   input  logic                 in_valid,
   input  gsfp_pkg::field_type  in_field,
   output logic                 in_ready,
   output logic                 out_valid,
   output gsfp_pkg::result_type out_result,
   input  logic                 out_ready
);
   import gsfp_pkg::*;

   // stage 1: decode time, then scale the magnitude one decade per cycle
   logic        s1_v_ff;
   field_type   s1_f_ff;
   logic [63:0] s1_mag_ff;
   logic [3:0]  s1_steps_ff;
   logic [13:0] s1_year_ff;
   logic [3:0]  s1_mon_ff;
   logic [4:0]  s1_day_ff, s1_hour_ff;
   logic [5:0]  s1_min_ff, s1_sec_ff;
   logic [9:0]  s1_ms_ff;
   // stage 2: result register
   logic        s2_v_ff;
   result_type  s2_r_ff;

   logic s1_go, s2_go, s1_done;
   assign s2_go    = !s2_v_ff || out_ready;
   assign s1_done  = s1_v_ff && (s1_steps_ff == 4'd0);
   assign s1_go    = !s1_v_ff || (s1_done && s2_go);
   assign in_ready = s1_go;
   assign out_valid  = s2_v_ff;
   assign out_result = s2_r_ff;

   // decades still missing; zero, saturated, integer, fully scaled and non-numeric fields need none
   logic [3:0]  steps;
   logic        no_scale;
   always_comb begin
      no_scale = (in_field.field_number == FIELD_INT0) ||
                 (in_field.field_number == FIELD_INT1) ||
                 (in_field.field_number == FIELD_TIME) ||
                 (in_field.field_number == FIELD_CHAR0) ||
                 (in_field.field_number == FIELD_CHAR1) ||
                 (in_field.frac >= 5'(SCALE_DIGITS)) ||
                 (in_field.mag == 64'd0) || (in_field.mag == MAG_CAP);
      steps = no_scale ? 4'd0 : 4'(5'(SCALE_DIGITS) - in_field.frac);
   end

   // time decode
   logic [6:0] yh, yl, mo, dy, hr, mi, se;
   logic [13:0] year;
   logic [3:0]  mon;
   logic [5:0]  day;
   logic [4:0]  hour, off;
   logic [5:0]  hsum;
   always_comb begin
      yh = two_dig(in_field.td[0], in_field.td[1]);
      yl = two_dig(in_field.td[2], in_field.td[3]);
      mo = two_dig(in_field.td[4], in_field.td[5]);
      dy = two_dig(in_field.td[6], in_field.td[7]);
      hr = two_dig(in_field.td[8], in_field.td[9]);
      mi = two_dig(in_field.td[10], in_field.td[11]);
      se = two_dig(in_field.td[12], in_field.td[13]);
      year = 14'(yh) * 14'd100 + 14'(yl);
      mon  = (mo > 7'd12) ? 4'd12 : mo[3:0];
      day  = (dy > 7'd31) ? 6'd31 : dy[5:0];
      hour = (hr > 7'd23) ? 5'd23 : hr[4:0];
      off  = (zone_offset_hours > 5'd23) ? 5'd23 : zone_offset_hours;
      hsum = 6'(hour) + 6'(off);
      if (hsum > 6'd23) begin
         hour = 5'(hsum - 6'd24);
         day  = day + 6'd1;
         if (mon == 4'd2 || mon == 4'd4 || mon == 4'd6 || mon == 4'd9 || mon == 4'd11) begin
            if (day > 6'd30) begin day = 6'd1; mon = mon + 4'd1; end
         end else if (day > 6'd31) begin
            day = 6'd1; mon = mon + 4'd1;
         end
         if (year[1:0] == 2'd0) begin
            if (day > 6'd29 && mon == 4'd2) begin day = 6'd1; mon = mon + 4'd1; end
         end else begin
            if (day > 6'd28 && mon == 4'd2) begin day = 6'd1; mon = mon + 4'd1; end
         end
         if (mon > 4'd12) begin mon = mon - 4'd12; year = year + 14'd1; end
      end else begin
         hour = hsum[4:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s1_steps_ff <= 4'd0;
      end else if (s1_go) begin
         s1_v_ff <= in_valid;
         s1_steps_ff <= in_valid ? steps : 4'd0;
      end else if (s1_steps_ff != 4'd0) begin
         s1_steps_ff <= s1_steps_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && in_valid) begin
         s1_f_ff    <= in_field;
         s1_mag_ff  <= in_field.mag;
         s1_year_ff <= year; s1_mon_ff <= mon; s1_day_ff <= day[4:0]; s1_hour_ff <= hour;
         s1_min_ff  <= (mi > 7'd59) ? 6'd59 : mi[5:0];
         s1_sec_ff  <= (se > 7'd59) ? 6'd59 : se[5:0];
         s1_ms_ff   <= 10'(in_field.td[15]) * 10'd100 + 10'(in_field.td[16]) * 10'd10;
      end else if (s1_v_ff && s1_steps_ff != 4'd0) begin
         s1_mag_ff  <= mul10_add(s1_mag_ff, 4'd0);
      end
   end

   // result assembly
   result_type r;
   logic [63:0] m;
   always_comb begin
      r = '0;
      r.field_number = s1_f_ff.field_number;
      r.line_end     = s1_f_ff.last;
      m = s1_mag_ff;
      if (s1_f_ff.field_number == FIELD_TIME) begin
         if (s1_f_ff.time_ok) begin
            r.time_valid = 1'b1; r.year_out = s1_year_ff; r.month_out = s1_mon_ff;
            r.day_out = s1_day_ff; r.hour_out = s1_hour_ff; r.minute_out = s1_min_ff;
            r.second_out = s1_sec_ff; r.millisecond_out = s1_ms_ff;
         end
      end else if (s1_f_ff.field_number == FIELD_CHAR0 ||
                   s1_f_ff.field_number == FIELD_CHAR1) begin
         r.char_value = s1_f_ff.len_nonzero ? s1_f_ff.first_char : 8'd0;
      end else if (s1_f_ff.neg) begin
         r.number_value = 64'd0 - m;
      end else begin
         r.number_value = (m > POS_MAX) ? POS_MAX : m;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (s2_go) begin
         s2_v_ff <= s1_done;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_go && s1_done) s2_r_ff <= r;
   end

`ifndef SYNTH
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (s2_v_ff && !out_ready) |=> s2_v_ff) else $error("result dropped");
   a_hour: assert property (@(posedge clock) disable iff (reset)
      s2_v_ff |-> s2_r_ff.hour_out <= 5'd23) else $error("hour out of range");
   a_time_only_f1: assert property (@(posedge clock) disable iff (reset)
      (s2_v_ff && s2_r_ff.time_valid) |-> s2_r_ff.field_number == FIELD_TIME)
      else $error("time on wrong field");
`endif
endmodule

// ===== rtl/gnss_sentence_field_parser.sv =====
// GNSS sentence field parser: one byte per cycle in while req_full is low, one result out
// per finished field 1 to FIELD_COUNT of a line whose fourth header character is T. Bytes
// pass a front end that accumulates each field as it arrives; finished fields pass a four
// entry queue to a two stage back end. The first stage decodes the time stamp and brings
// a decimal field up to SCALE_DIGITS fraction digits at one multiply by ten per cycle; the
// second holds the result. A field that is zero, saturated, an integer, a time or char
// field, or already has SCALE_DIGITS fraction digits needs no multiply; any other takes
// one for each missing fraction digit. A result passes the queue, the first stage and the
// result register before it shows on the rsp_ ports. full rises only when the queue fills,
// either because the consumer holds results back or because short decimal fields close
// faster than the back end scales them.
module gnss_sentence_field_parser #(
   parameter int SCALE_DIGITS = 7,
   parameter int FIELD_COUNT  = 19
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   output logic         req_full,
   input  logic [7:0]   req_data_byte,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output logic [4:0]   rsp_field_number,
   output logic signed [63:0] rsp_number_value,
   output logic [7:0]   rsp_char_value,
   output logic         rsp_time_valid,
   output logic [13:0]  rsp_year_out,
   output logic [3:0]   rsp_month_out,
   output logic [4:0]   rsp_day_out,
   output logic [4:0]   rsp_hour_out,
   output logic [5:0]   rsp_minute_out,
   output logic [5:0]   rsp_second_out,
   output logic [9:0]   rsp_millisecond_out,
   output logic         rsp_line_end,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [1:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);
   import gsfp_pkg::*;

   logic [4:0] zone_ff;
   logic       q_full, fr_valid, q_valid, bk_ready, bk_valid, in_take;
   field_type  fr_field, q_field;
   result_type res;

   assign pready   = 1'b1;
   assign prdata   = {27'd0, zone_ff};
   assign req_full = q_full;
   assign in_take  = req_push && !q_full;

   // zone offset register
   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff <= 5'd8;
      end else if (psel && penable && pwrite && paddr[1:0] == {CSR_ZONE, 1'b0}) begin
         zone_ff <= pwdata[4:0];
      end
   end

   gsfp_front #(.SCALE_DIGITS(SCALE_DIGITS), .FIELD_COUNT(FIELD_COUNT)) u_front (
      .clock(clock), .reset(reset), .in_valid(in_take), .in_byte(req_data_byte),
      .out_valid(fr_valid), .out_field(fr_field));

   gsfp_queue #(.DEPTH(4)) u_queue (
      .clock(clock), .reset(reset), .wr_en(fr_valid), .wr_data(fr_field),
      .full(q_full), .rd_en(q_valid && bk_ready), .rd_valid(q_valid), .rd_data(q_field));

   gsfp_back #(.SCALE_DIGITS(SCALE_DIGITS)) u_back (
      .clock(clock), .reset(reset), .zone_offset_hours(zone_ff),
      .in_valid(q_valid), .in_field(q_field), .in_ready(bk_ready),
      .out_valid(bk_valid), .out_result(res), .out_ready(rsp_pop));

   assign rsp_empty           = !bk_valid;
   assign rsp_field_number    = res.field_number;
   assign rsp_number_value    = res.number_value;
   assign rsp_char_value      = res.char_value;
   assign rsp_time_valid      = res.time_valid;
   assign rsp_year_out        = res.year_out;
   assign rsp_month_out       = res.month_out;
   assign rsp_day_out         = res.day_out;
   assign rsp_hour_out        = res.hour_out;
   assign rsp_minute_out      = res.minute_out;
   assign rsp_second_out      = res.second_out;
   assign rsp_millisecond_out = res.millisecond_out;
   assign rsp_line_end        = res.line_end;

`ifndef SYNTH
   a_zone_write: assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && paddr == 2'd0) |=> zone_ff == $past(pwdata[4:0]))
      else $error("zone write lost");
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !in_take) else $error("beat taken while full");
   a_prdata: assert property (@(posedge clock) disable iff (reset)
      prdata[31:5] == 27'd0) else $error("read data upper bits set");
`endif
endmodule

// ===== tb/gsfp_checker.sv =====
// checker: predicts the parser's results from the observed bytes and compares them
`timescale 1ns / 100ps

module gsfp_checker
   import gsfp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  logic               req_full,
   input  logic [7:0]         req_data_byte,
   input  logic               rsp_empty,
   input  logic               rsp_pop,
   input  logic [4:0]         rsp_field_number,
   input  logic signed [63:0] rsp_number_value,
   input  logic [7:0]         rsp_char_value,
   input  logic               rsp_time_valid,
   input  logic [13:0]        rsp_year_out,
   input  logic [3:0]         rsp_month_out,
   input  logic [4:0]         rsp_day_out,
   input  logic [4:0]         rsp_hour_out,
   input  logic [5:0]         rsp_minute_out,
   input  logic [5:0]         rsp_second_out,
   input  logic [9:0]         rsp_millisecond_out,
   input  logic               rsp_line_end,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [1:0]         paddr,
   input  logic [31:0]        pwdata,
   input  logic               pready,
   output int                 fail_count,
   output int                 pending_fields,
   output int                 fields_seen,
   output int                 bytes_seen
);

   localparam int SCALE = 7;
   localparam int LAST_FIELD = 19;
   localparam logic [1:0] ZONE_ADDR = 2'(4 * CSR_ZONE);

   // mirror of the parser state
   logic [4:0]  zone;
   logic [2:0]  line_pos;
   logic        hdr_ok, in_line_q, over, done_num, started;
   logic [4:0]  fld_cnt;
   logic [5:0]  fld_len;
   logic [63:0] mag;
   logic        neg, pt;
   logic [4:0]  frac;
   logic [7:0]  first_ch;
   logic [3:0]  digits [17];

   result_type field_q [$];

   // saturating decimal shift of the magnitude
   function automatic logic [63:0] scale10(input logic [63:0] m, input logic [3:0] d);
      if (m > (MAG_CAP - 64'(d)) / 64'd10) return MAG_CAP;
      return m * 64'd10 + 64'(d);
   endfunction

   function automatic int pair(input int i);
      return int'(digits[i]) * 10 + int'(digits[i + 1]);
   endfunction

   function automatic int clip(input int v, input int hi);
      return v > hi ? hi : v;
   endfunction

   function automatic result_type field_result(input logic last);
      result_type r;
      logic [63:0] m;
      int yr, mo, dy, hr, off;
      r = '0;
      r.field_number = fld_cnt;
      r.line_end = last;
      if (fld_cnt == FIELD_TIME) begin
         if (fld_len == 6'(TIME_LEN)) begin
            yr = pair(0) * 100 + pair(2);
            mo = clip(pair(4), 12);
            dy = clip(pair(6), 31);
            hr = clip(pair(8), 23);
            off = clip(int'(zone), 23);
            hr = hr + off;
            // day, month and year rollover
            if (hr > 23) begin
               hr = hr - 24;
               dy = dy + 1;
               if (mo == 2 || mo == 4 || mo == 6 || mo == 9 || mo == 11) begin
                  if (dy > 30) begin dy = 1; mo = mo + 1; end
               end else begin
                  if (dy > 31) begin dy = 1; mo = mo + 1; end
               end
               if (yr % 4 == 0) begin
                  if (dy > 29 && mo == 2) begin dy = 1; mo = mo + 1; end
               end else begin
                  if (dy > 28 && mo == 2) begin dy = 1; mo = mo + 1; end
               end
               if (mo > 12) begin mo = mo - 12; yr = yr + 1; end
            end
            r.time_valid = 1'b1;
            r.year_out = 14'(yr);
            r.month_out = 4'(mo);
            r.day_out = 5'(dy);
            r.hour_out = 5'(hr);
            r.minute_out = 6'(clip(pair(10), 59));
            r.second_out = 6'(clip(pair(12), 59));
            r.millisecond_out = 10'(int'(digits[15]) * 100 + int'(digits[16]) * 10);
         end
      end else if (fld_cnt == FIELD_CHAR0 || fld_cnt == FIELD_CHAR1) begin
         r.char_value = (fld_len != 0) ? first_ch : 8'd0;
      end else begin
         m = mag;
         if (fld_cnt != FIELD_INT0 && fld_cnt != FIELD_INT1)
            for (int k = int'(frac); k < SCALE; k++) m = scale10(m, 4'd0);
         if (neg) r.number_value = 64'd0 - m;
         else r.number_value = (m > POS_MAX) ? POS_MAX : m;
      end
      return r;
   endfunction

   function automatic logic reportable();
      return in_line_q && hdr_ok && !over && fld_cnt >= 1 && fld_cnt <= LAST_FIELD;
   endfunction

   task automatic clear_field();
      fld_len = '0;
      mag = '0;
      neg = 1'b0;
      pt = 1'b0;
      frac = '0;
      first_ch = '0;
      done_num = 1'b0;
      started = 1'b0;
   endtask

   // numeric accumulation of one field character
   task automatic add_char(input logic [7:0] c);
      logic is_dig, int_fld;
      is_dig = (c >= CHAR_ZERO && c <= CHAR_NINE);
      int_fld = (fld_cnt == FIELD_INT0 || fld_cnt == FIELD_INT1);
      if (fld_cnt == FIELD_TIME && fld_len < 6'(TIME_LEN))
         digits[fld_len] = is_dig ? 4'(c - CHAR_ZERO) : 4'd0;
      if (fld_len == 0) first_ch = c;
      if (fld_len < 6'd63) fld_len = fld_len + 6'd1;
      if (!done_num) begin
         if (is_dig) begin
            started = 1'b1;
            if (pt) begin
               if (frac < 5'(SCALE)) begin
                  mag = scale10(mag, 4'(c - CHAR_ZERO));
                  frac = frac + 5'd1;
               end
            end else begin
               mag = scale10(mag, 4'(c - CHAR_ZERO));
            end
         end else if (!started && (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_VTAB ||
                                   c == CHAR_FF)) begin
            // leading blank
         end else if (!started && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
            started = 1'b1;
            neg = (c == CHAR_MINUS);
         end else if (c == CHAR_POINT && !pt && !int_fld) begin
            started = 1'b1;
            pt = 1'b1;
         end else begin
            done_num = 1'b1;
         end
      end
   endtask

   // one accepted input byte
   task automatic take_byte(input logic [7:0] c);
      if (c == CHAR_DOLLAR) begin
         in_line_q = 1'b1;
         line_pos = '0;
         hdr_ok = 1'b0;
         fld_cnt = '0;
         over = 1'b0;
         clear_field();
      end else if (in_line_q) begin
         if (c == CHAR_CR || c == CHAR_LF) begin
            if (reportable()) field_q.push_back(field_result(1'b1));
            in_line_q = 1'b0;
            clear_field();
         end else begin
            if (line_pos < 3'd7) line_pos = line_pos + 3'd1;
            if (line_pos == 3'd4 && c == CHAR_T) hdr_ok = 1'b1;
            if (c == CHAR_COMMA) begin
               if (reportable()) field_q.push_back(field_result(1'b0));
               if (fld_cnt >= 5'(LAST_FIELD)) over = 1'b1;
               else fld_cnt = fld_cnt + 5'd1;
               clear_field();
            end else begin
               add_char(c);
            end
         end
      end
   endtask

   task automatic cmp(input string name, input logic [63:0] exp_v, input logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   assign pending_fields = field_q.size();

   initial begin
      fail_count = 0;
      fields_seen = 0;
      bytes_seen = 0;
   end

   always @(posedge clock) begin
      result_type e;
      if (reset) begin
         zone = 5'd8;
         line_pos = '0;
         hdr_ok = 1'b0;
         in_line_q = 1'b0;
         fld_cnt = '0;
         over = 1'b0;
         for (int i = 0; i < 17; i++) digits[i] = '0;
         clear_field();
         field_q.delete();
      end else begin
         // register write
         if (psel && penable && pwrite && pready && paddr == ZONE_ADDR)
            zone = pwdata[4:0];
         // result beat
         if (rsp_pop && !rsp_empty) begin
            fields_seen++;
            if (field_q.size() == 0) begin
               $error("result beat for field %0d with nothing expected", rsp_field_number);
               fail_count++;
            end else begin
               e = field_q.pop_front();
               cmp("field_number", 64'(e.field_number), 64'(rsp_field_number));
               cmp("number_value", e.number_value, rsp_number_value);
               cmp("char_value", 64'(e.char_value), 64'(rsp_char_value));
               cmp("time_valid", 64'(e.time_valid), 64'(rsp_time_valid));
               cmp("year_out", 64'(e.year_out), 64'(rsp_year_out));
               cmp("month_out", 64'(e.month_out), 64'(rsp_month_out));
               cmp("day_out", 64'(e.day_out), 64'(rsp_day_out));
               cmp("hour_out", 64'(e.hour_out), 64'(rsp_hour_out));
               cmp("minute_out", 64'(e.minute_out), 64'(rsp_minute_out));
               cmp("second_out", 64'(e.second_out), 64'(rsp_second_out));
               cmp("millisecond_out", 64'(e.millisecond_out), 64'(rsp_millisecond_out));
               cmp("line_end", 64'(e.line_end), 64'(rsp_line_end));
            end
         end
         // input beat
         if (req_push && !req_full) begin
            bytes_seen++;
            take_byte(req_data_byte);
         end
      end
   end

endmodule

// ===== tb/tb_gnss_sentence_field_parser.sv =====
// testbench top: sentence stimulus, register writes and verdict for the field parser
`timescale 1ns / 100ps

module tb_gnss_sentence_field_parser;
   import gsfp_pkg::*;

   localparam logic [1:0] ZONE_ADDR = 2'(4 * CSR_ZONE);

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic [7:0] req_data_byte = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic [4:0] rsp_field_number;
   logic signed [63:0] rsp_number_value;
   logic [7:0] rsp_char_value;
   logic rsp_time_valid;
   logic [13:0] rsp_year_out;
   logic [3:0] rsp_month_out;
   logic [4:0] rsp_day_out, rsp_hour_out;
   logic [5:0] rsp_minute_out, rsp_second_out;
   logic [9:0] rsp_millisecond_out;
   logic rsp_line_end;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   int fail_count, pending_fields, fields_seen, bytes_seen;

   // stimulus controls
   logic [7:0] byte_q [$];
   bit burst_mode = 1'b0;
   bit hold_long = 1'b0;
   bit drain_burst = 1'b0;

   always #5 clock = ~clock;

   gnss_sentence_field_parser DUT (.*);

   gsfp_checker u_checker (.*);

   // run limit
   initial begin
      #20ms;
      $display("TEST FAILED");
      $finish;
   end

   // result side: random stalls, one long hold on request
   initial begin
      int gap;
      @(negedge clock);
      wait (!reset);
      forever begin
         if (hold_long) begin
            gap = 400;
            hold_long = 1'b0;
         end else if (drain_burst) gap = 0;
         else gap = $urandom_range(0, 14);
         if (gap > 0) begin
            @(negedge clock) rsp_pop <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         @(negedge clock) rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         @(negedge clock) req_push <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_push <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (req_full);
   endtask

   task automatic flush_bytes();
      while (byte_q.size() > 0) send_byte(byte_q.pop_front());
      @(negedge clock) req_push <= 1'b0;
   endtask

   // wait for every field to come out, then let the pipeline settle
   task automatic drain();
      wait (pending_fields == 0);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_zone(input logic [4:0] hours);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ZONE_ADDR;
      pwdata <= 32'(hours);
      @(negedge clock) penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic add_str(input string s);
      for (int i = 0; i < s.len(); i++) byte_q.push_back(s[i]);
   endtask

   // any byte that does not end a field or a line
   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b == CHAR_DOLLAR || b == CHAR_COMMA || b == CHAR_CR || b == CHAR_LF);
      return b;
   endfunction

   function automatic logic [7:0] digit_byte();
      return CHAR_ZERO + 8'($urandom_range(0, 9));
   endfunction

   task automatic add_two(input int v);
      byte_q.push_back(CHAR_ZERO + 8'(v / 10));
      byte_q.push_back(CHAR_ZERO + 8'(v % 10));
   endtask

   task automatic add_time_field();
      int n;
      if ($urandom_range(0, 99) < 85) begin
         add_two($urandom_range(0, 99));
         add_two($urandom_range(0, 99));
         add_two($urandom_range(0, 3) == 0 ? $urandom_range(0, 99) : $urandom_range(1, 12));
         add_two($urandom_range(0, 3) == 0 ? $urandom_range(0, 99) : $urandom_range(27, 31));
         add_two($urandom_range(0, 4) == 0 ? $urandom_range(0, 99) : $urandom_range(0, 23));
         add_two($urandom_range(0, 99));
         add_two($urandom_range(0, 99));
         byte_q.push_back(CHAR_POINT);
         add_two($urandom_range(0, 99));
      end else begin
         // random length with mixed digit and non-digit content
         n = $urandom_range(0, 20);
         for (int i = 0; i < n; i++)
            byte_q.push_back($urandom_range(0, 1) ? digit_byte() : plain_byte());
      end
   endtask

   task automatic add_number(input bit int_fld);
      int n;
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
         case ($urandom_range(0, 3))
            0: byte_q.push_back(CHAR_SPACE);
            1: byte_q.push_back(CHAR_TAB);
            2: byte_q.push_back(CHAR_VTAB);
            default: byte_q.push_back(CHAR_FF);
         endcase
      case ($urandom_range(0, 3))
         0: byte_q.push_back(CHAR_MINUS);
         1: byte_q.push_back(CHAR_PLUS);
         default: ;
      endcase
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(18, 24) : $urandom_range(0, 6);
      repeat (n) byte_q.push_back(digit_byte());
      if ($urandom_range(0, 2) != 0) begin
         byte_q.push_back(CHAR_POINT);
         repeat ($urandom_range(0, 10)) byte_q.push_back(digit_byte());
      end
      // trailing rubbish ends the number
      if ($urandom_range(0, 7) == 0) begin
         byte_q.push_back(plain_byte());
         repeat ($urandom_range(0, 3)) byte_q.push_back(digit_byte());
      end
   endtask

   task automatic add_sentence();
      int nf;
      byte_q.push_back(CHAR_DOLLAR);
      if ($urandom_range(0, 19) == 0) byte_q.push_back(CHAR_COMMA);
      repeat (3) byte_q.push_back(8'($urandom_range(8'h41, 8'h5A)));
      byte_q.push_back($urandom_range(0, 9) == 0 ? plain_byte() : CHAR_T);
      repeat ($urandom_range(0, 2)) byte_q.push_back(8'($urandom_range(8'h41, 8'h5A)));
      nf = ($urandom_range(0, 9) < 8) ? 19 : $urandom_range(0, 23);
      for (int f = 1; f <= nf; f++) begin
         byte_q.push_back(CHAR_COMMA);
         if (f == 1) add_time_field();
         else if (f == 10 || f == 11) begin
            if ($urandom_range(0, 4) != 0) begin
               byte_q.push_back(plain_byte());
               repeat ($urandom_range(0, 2)) byte_q.push_back(plain_byte());
            end
         end else add_number(f == 12 || f == 13);
      end
      // line end, sometimes a fresh start or stray bytes
      case ($urandom_range(0, 9))
         0: ;
         1: begin
            byte_q.push_back(CHAR_CR);
            repeat ($urandom_range(1, 6)) byte_q.push_back(8'($urandom_range(0, 255)));
            byte_q.push_back(CHAR_LF);
         end
         2, 3: begin
            byte_q.push_back(CHAR_CR);
            byte_q.push_back(CHAR_LF);
         end
         4, 5: byte_q.push_back(CHAR_LF);
         default: byte_q.push_back(CHAR_CR);
      endcase
   endtask

   initial begin
      logic [4:0] zones [4];
      zones = '{5'd0, 5'd31, 5'd8, 5'd1};
      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed: extremes, rollover, leap day, saturation, odd framing
      write_zone(5'd23);
      add_str("xx$GPST,99991231235959.99,-9999999999999999999,99999999999999999999.5");
      add_str(",+1.123456789,  -0.5,.,-,7,8,A,,99999999999999999999,-123.4,x,,,,,,,9\r");
      add_str("$GPST,20240228235900.50,,,,,,,,,,\n");
      add_str("$GPST,20230228230000.00\r$GPST,2023022823000.00\r");
      add_str("$GP,T,1,2\r$GPSX,1,2\r$GPST\r$GPST,1$GPST,");
      add_str("11,2,3,4,5,6,7,8,9,10,11,12,13,14,15,16,17,18,19,20,21\n");
      burst_mode = 1'b1;
      flush_bytes();
      drain();

      // long result hold so the input stalls
      burst_mode = 1'b1;
      hold_long = 1'b1;
      add_sentence();
      flush_bytes();
      drain();

      // random phases across zone settings
      for (int p = 0; p < 4; p++) begin
         write_zone(p == 3 ? 5'($urandom_range(0, 31)) : zones[p]);
         while (byte_q.size() < 100) add_sentence();
         repeat ($urandom_range(0, 4)) byte_q.push_back(8'($urandom_range(0, 255)));
         burst_mode = (p == 1);
         drain_burst = (p == 1);
         flush_bytes();
         drain();
      end
      drain_burst = 1'b0;

      $display("covered %0d bytes in, %0d fields checked, zone offsets 0, 1, 8, 23, 31 and random",
               bytes_seen, fields_seen);
      if (fail_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/gsfp_pkg.sv
rtl/gsfp_front.sv
rtl/gsfp_queue.sv
rtl/gsfp_back.sv
rtl/gnss_sentence_field_parser.sv
tb/gsfp_checker.sv
tb/tb_gnss_sentence_field_parser.sv
